// ===== design/tanp_pkg.sv =====
package tanp_pkg;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;

    // Field kinds, as carried on the mode input.
    localparam logic [3:0] KIND_I8    = 4'd0;
    localparam logic [3:0] KIND_U8    = 4'd1;
    localparam logic [3:0] KIND_I16   = 4'd2;
    localparam logic [3:0] KIND_U16   = 4'd3;
    localparam logic [3:0] KIND_U24   = 4'd4;
    localparam logic [3:0] KIND_I32   = 4'd5;
    localparam logic [3:0] KIND_U32   = 4'd6;
    localparam logic [3:0] KIND_HEX8  = 4'd7;
    localparam logic [3:0] KIND_HEX16 = 4'd8;
    localparam logic [3:0] KIND_HEX24 = 4'd9;
    localparam logic [3:0] KIND_HEX32 = 4'd10;
    localparam logic [3:0] KIND_CHAR  = 4'd11;
    localparam logic [3:0] KIND_UCHAR = 4'd12;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MISSING  = 3'd1;
    localparam logic [2:0] ST_NO_COMMA = 3'd2;
    localparam logic [2:0] ST_LIMIT    = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
        logic [3:0] mode;
        logic       optional;
    } item_t;

    typedef struct packed {
        logic        done_res;
        logic        byte_taken;
        logic [2:0]  status;
        logic [31:0] value;
        logic        raise_error;
    } result_t;

    function automatic logic [3:0] digit_count(input logic [3:0] kind);
        logic [3:0] n;
        begin
            case (kind)
                KIND_I8, KIND_U8:   n = 4'd3;
                KIND_I16, KIND_U16: n = 4'd5;
                KIND_U24:           n = 4'd8;
                KIND_I32, KIND_U32: n = 4'd10;
                KIND_HEX8:          n = 4'd2;
                KIND_HEX16:         n = 4'd4;
                KIND_HEX24:         n = 4'd6;
                KIND_HEX32:         n = 4'd8;
                default:            n = 4'd0;
            endcase
            return n;
        end
    endfunction

    function automatic logic [31:0] type_mask(input logic [3:0] kind);
        logic [31:0] m;
        begin
            case (kind)
                KIND_I16, KIND_U16, KIND_HEX16: m = 32'h0000_FFFF;
                KIND_U24, KIND_HEX24:           m = 32'h00FF_FFFF;
                KIND_I32, KIND_U32, KIND_HEX32: m = 32'hFFFF_FFFF;
                default:                        m = 32'h0000_00FF;
            endcase
            return m;
        end
    endfunction

    function automatic logic out_of_limit(input logic [3:0] kind, input logic neg,
                                          input logic [31:0] a);
        logic r;
        begin
            if (neg)
            begin
                r = (kind == KIND_I8  && a > 32'h0000_0080) ||
                    (kind == KIND_I16 && a > 32'h0000_8000) ||
                    (kind == KIND_I32 && a > 32'h8000_0000);
            end
            else
            begin
                r = (kind == KIND_I8  && a > 32'h0000_007F) ||
                    (kind == KIND_U8  && a > 32'h0000_00FF) ||
                    (kind == KIND_I16 && a > 32'h0000_7FFF) ||
                    (kind == KIND_U16 && a > 32'h0000_FFFF) ||
                    (kind == KIND_U24 && a > 32'h00FF_FFFF) ||
                    (kind == KIND_I32 && a > 32'h7FFF_FFFF);
            end
            return r;
        end
    endfunction

    // Returns {bad, digit}; bad is set when the byte is no digit of the base.
    function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
        logic [4:0] r;
        logic [7:0] t;
        begin
            r = 5'h10;
            t = 8'd0;
            if (b >= 8'd48 && b <= 8'd57)
            begin
                t = b - 8'd48;
                r = {1'b0, t[3:0]};
            end
            else if (hex && b >= 8'd97 && b <= 8'd102)
            begin
                t = b - 8'd87;
                r = {1'b0, t[3:0]};
            end
            else if (hex && b >= 8'd65 && b <= 8'd70)
            begin
                t = b - 8'd55;
                r = {1'b0, t[3:0]};
            end
            return r;
        end
    endfunction

endpackage

// ===== design/tanp_core.sv =====
module tanp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tanp_pkg::item_t  item,
    output tanp_pkg::result_t result
);
    import tanp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_COMMA  = 3'd1,
        PH_SIGN   = 3'd2,
        PH_DIGITS = 3'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  kind_reg, kind_next;
    logic        opt_reg, opt_next;
    logic        neg_reg, neg_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  left_reg, left_next;

    // Field state as seen by this byte, after a possible restart.
    phase_t      ph;
    logic [3:0]  k;
    logic        opt;
    logic        neg;
    logic [31:0] acc;
    logic [3:0]  left;

    // Shared digit step.
    logic        hex;
    logic [4:0]  dig;
    logic [3:0]  ds_left;
    logic [31:0] ds_acc;
    logic [31:0] acc_step;
    logic [3:0]  left_step;
    logic        ds_take;
    logic        ds_done;
    logic [31:0] fin_acc;
    logic        fin_bad;
    logic [31:0] fin_val;
    logic [7:0]  ch;

    always_comb
    begin
        ph   = item.start_req ? PH_COMMA : phase_reg;
        k    = item.start_req ? item.mode : kind_reg;
        opt  = item.start_req ? item.optional : opt_reg;
        neg  = item.start_req ? 1'b0 : neg_reg;
        acc  = item.start_req ? 32'd0 : acc_reg;
        left = item.start_req ? 4'd0 : left_reg;

        hex     = (k >= KIND_HEX8) && (k <= KIND_HEX32);
        dig     = digit_of(item.data_byte, hex);
        ds_left = (ph == PH_SIGN) ? digit_count(k) : left;
        ds_acc  = (ph == PH_SIGN) ? 32'd0 : acc;
        if (hex)
        begin
            acc_step = {ds_acc[27:0], dig[3:0]};
        end
        else
        begin
            acc_step = {ds_acc[28:0], 3'b000} + {ds_acc[30:0], 1'b0} + {28'd0, dig[3:0]};
        end
        left_step = ds_left - 4'd1;
        ds_take   = !dig[4] && (ds_left != 4'd0);
        ds_done   = !ds_take || (left_step == 4'd0);
        fin_acc   = ds_take ? acc_step : ds_acc;
        fin_bad   = out_of_limit(k, neg, fin_acc);
        fin_val   = (neg ? (32'd0 - fin_acc) : fin_acc) & type_mask(k);

        ch = item.data_byte;
        if (k == KIND_UCHAR && ch >= 8'd97 && ch <= 8'd122)
        begin
            ch = ch - 8'd32;
        end

        result     = '0;
        phase_next = ph;
        kind_next  = k;
        opt_next   = opt;
        neg_next   = neg;
        acc_next   = acc;
        left_next  = left;

        unique case (ph)
            PH_COMMA:
            begin
                if (item.data_byte == CH_CR)
                begin
                    result.done_res    = 1'b1;
                    result.status      = ST_MISSING;
                    result.raise_error = !opt;
                end
                else if (item.data_byte != CH_COMMA)
                begin
                    result.done_res    = 1'b1;
                    result.status      = ST_NO_COMMA;
                    result.raise_error = !opt;
                end
                else
                begin
                    result.byte_taken = 1'b1;
                    phase_next        = PH_SIGN;
                end
            end
            PH_SIGN, PH_DIGITS:
            begin
                if (ph == PH_SIGN && item.data_byte == CH_CR)
                begin
                    result.done_res    = 1'b1;
                    result.status      = ST_MISSING;
                    result.raise_error = !opt;
                end
                else if (ph == PH_SIGN && (k == KIND_CHAR || k == KIND_UCHAR))
                begin
                    result.done_res   = 1'b1;
                    result.byte_taken = 1'b1;
                    result.value      = {24'd0, ch};
                end
                else if (ph == PH_SIGN && k > KIND_UCHAR)
                begin
                    result.done_res   = 1'b1;
                    result.byte_taken = (item.data_byte == CH_MINUS);
                    result.status     = ST_INVALID;
                end
                else if (ph == PH_SIGN && item.data_byte == CH_MINUS)
                begin
                    left_next = ds_left;
                    acc_next  = 32'd0;
                    if (k == KIND_U8 || k == KIND_U16 || k == KIND_U32 || k == KIND_HEX32)
                    begin
                        result.done_res    = 1'b1;
                        result.status      = ST_LIMIT;
                        result.raise_error = 1'b1;
                    end
                    else
                    begin
                        result.byte_taken = 1'b1;
                        neg_next          = 1'b1;
                        phase_next        = PH_DIGITS;
                    end
                end
                else
                begin
                    phase_next        = PH_DIGITS;
                    acc_next          = fin_acc;
                    left_next         = ds_take ? left_step : ds_left;
                    result.byte_taken = ds_take;
                    result.done_res   = ds_done;
                    if (ds_done)
                    begin
                        if (fin_bad)
                        begin
                            result.status      = ST_LIMIT;
                            result.raise_error = 1'b1;
                        end
                        else
                        begin
                            result.value = fin_val;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (result.done_res)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= 4'd0;
            opt_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            acc_reg   <= 32'd0;
            left_reg  <= 4'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            opt_reg   <= opt_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== design/typed_ascii_number_field_parser.sv =====
// Channel | Handshake             | Payload
// --------+-----------------------+---------------------------------------------------
// input   | in_valid / in_stall   | data_byte, start_req, mode, optional
// output  | out_valid / out_stall | done_res, byte_taken, status, value, raise_error
//
// Every input beat yields exactly one output beat, through the input register and
// then the result register. While the output does not stall, a new beat can be
// accepted every cycle; the rate is set by the single field-state register, which
// each beat updates. Reset (rst_n low) empties both stages and closes any open field.
// A stall on the output holds the result register and then the input register;
// in_stall rises only while the input register is full and cannot move on.
module typed_ascii_number_field_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    input  logic [3:0]  mode,
    input  logic        optional,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        done_res,
    output logic        byte_taken,
    output logic [2:0]  status,
    output logic [31:0] value,
    output logic        raise_error
);
    import tanp_pkg::*;

    // Input register: holds the beat that the parser works on next.
    logic    in_valid_reg, in_valid_next;
    item_t   item_reg, item_next;

    // Result register: holds the finished beat until the consumer takes it.
    logic    out_valid_reg, out_valid_next;
    result_t res_reg, res_next;

    result_t core_res;
    logic    advance;
    logic    accept;

    // The parser fires when a beat is waiting and the result register is free
    // or is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    tanp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (core_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            item_next     = '{data_byte: data_byte, start_req: start_req,
                              mode: mode, optional: optional};
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            res_next       = core_res;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign done_res    = res_reg.done_res;
    assign byte_taken  = res_reg.byte_taken;
    assign status      = res_reg.status;
    assign value       = res_reg.value;
    assign raise_error = res_reg.raise_error;

endmodule
